[hdl/mlba_pkg.sv]
package mlba_pkg;

	localparam int MaxSources = 16;
	localparam int MaxLanes   = 4;
	localparam int SrcW       = 4;
	localparam int LaneW      = 2;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_BANDWIDTH = 2'd0;
	localparam logic [1:0] REG_SOURCES   = 2'd1;
	localparam logic [1:0] REG_LANES     = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_GRANT = 2'd0;
	localparam logic [1:0] ST_STALL = 2'd1;
	localparam logic [1:0] ST_NOLANE = 2'd2;
	localparam logic [1:0] ST_TICK  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LANE,
		S_SCAN,
		S_DIV,
		S_STAMP,
		S_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic tick;
		logic lane_start;
		logic scan_step;
		logic div_start;
		logic div_step;
		logic stamp;
		logic res_stall;
		logic res_nolane;
		logic res_tick;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic req;
		logic dest_rdy;
		logic lane_cached;
		logic lane_busy;
		logic scan_hit;
		logic scan_last;
		logic lane_match;
		logic lane_last;
		logic div_done;
	} sts_t;

endpackage

[hdl/mlba_ctrl.sv]
module mlba_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output mlba_pkg::cmd_t  cmd,
	input  mlba_pkg::sts_t  sts
);
	import mlba_pkg::*;

	state_t state_q, state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_LANE;
			end
			S_LANE: begin
				if (!sts.req || !sts.dest_rdy) state_d = S_OUT;
				else if (sts.lane_cached || sts.lane_busy) begin
					if (sts.lane_match) state_d = S_DIV;
					else if (sts.lane_last) state_d = S_OUT;
				end else state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_hit || sts.scan_last) begin
					if (sts.lane_match) state_d = S_DIV;
					else if (sts.lane_last) state_d = S_OUT;
					else state_d = S_LANE;
				end
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_STAMP;
			end
			S_STAMP: state_d = S_OUT;
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_LANE: begin
				if (!sts.req) cmd.tick = 1'b1;
				else if (!sts.dest_rdy) cmd.res_stall = 1'b1;
				else if (sts.lane_cached || sts.lane_busy) begin
					cmd.lane_start = 1'b1;
					if (sts.lane_match) cmd.div_start = 1'b1;
					else if (sts.lane_last) cmd.res_nolane = 1'b1;
				end else cmd.lane_start = 1'b1;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit || sts.scan_last) begin
					if (sts.lane_match) cmd.div_start = 1'b1;
					else if (sts.lane_last) cmd.res_nolane = 1'b1;
				end
			end
			S_DIV: cmd.div_step = 1'b1;
			S_STAMP: cmd.stamp = 1'b1;
			S_OUT: out_valid = 1'b1;
			default: ;
		endcase
		cmd.res_tick = cmd.tick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

[hdl/mlba_dp.sv]
module mlba_dp (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [7:0]              cfg_data,
	input  logic                    req_type,
	input  logic [mlba_pkg::SrcW-1:0] source_index,
	input  logic [15:0]             pkt_bytes,
	input  logic [15:0]             head_ready_mask,
	input  logic                    dest_ready,
	input  mlba_pkg::cmd_t          cmd,
	output mlba_pkg::sts_t          sts,
	output logic [1:0]              status,
	output logic [1:0]              granted_lane,
	output logic [15:0]             transfer_latency,
	output logic [31:0]             busy_until
);
	import mlba_pkg::*;

	// Configuration
	logic [7:0] bw_q;
	logic [4:0] nsrc_cfg_q;
	logic [2:0] nlane_cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q <= 8'd8;
			nsrc_cfg_q <= 5'd16;
			nlane_cfg_q <= 3'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BANDWIDTH: bw_q <= cfg_data;
				REG_SOURCES:   nsrc_cfg_q <= cfg_data[4:0];
				REG_LANES:     nlane_cfg_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Clamped counts
	logic [4:0] nsrc;
	logic [2:0] nlane;
	assign nsrc = (nsrc_cfg_q == 5'd0) ? 5'd1 : (nsrc_cfg_q > 5'd16 ? 5'd16 : nsrc_cfg_q);
	assign nlane = (nlane_cfg_q == 3'd0) ? 3'd1 : (nlane_cfg_q > 3'd4 ? 3'd4 : nlane_cfg_q);

	// Captured item
	logic              req_q, dest_q;
	logic [SrcW-1:0]   src_q;
	logic [15:0]       size_q, mask_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			dest_q <= dest_ready;
			src_q <= source_index;
			size_q <= pkt_bytes;
			mask_q <= head_ready_mask;
		end
	end

	// Arbitration state
	logic [31:0]       cycle_q;
	logic [SrcW-1:0]   last_q;
	logic [32:0]       lane_busy_q [MaxLanes];
	logic [MaxLanes-1:0] dec_valid_q;
	logic [4:0]        choice_q [MaxLanes];
	logic [32:0]       src_busy_q [MaxSources];
	logic [LaneW-1:0]  lane_q;
	logic [4:0]        step_q;
	logic [SrcW-1:0]   cand_q;

	logic still_lane, still_src, cand_ok, src_ok;
	logic [4:0] cur_choice;
	assign still_lane = !lane_busy_q[lane_q][32] && (lane_busy_q[lane_q][31:0] >= cycle_q);
	assign still_src = !src_busy_q[cand_q][32] && (src_busy_q[cand_q][31:0] >= cycle_q);
	assign cand_ok = mask_q[cand_q] && !still_src;
	assign src_ok = {1'b0, src_q} < nsrc;

	// Small remainder by compare and subtract; v stays at or below 16
	function automatic logic [4:0] wrap_src(logic [4:0] v, logic [4:0] n);
		logic [4:0] r;
		r = v;
		for (int k = 4; k >= 0; k--) begin
			if ({5'd0, r} >= ({5'd0, n} << k)) r = r - 5'({5'd0, n} << k);
		end
		return r;
	endfunction

	// Candidate for the first scan step: (last + 1) mod nsrc
	logic [4:0] first_cand;
	assign first_cand = wrap_src({1'b0, last_q} + 5'd1, nsrc);

	// Choice visible this cycle for the lane under test
	always_comb begin
		cur_choice = 5'h10;
		if (dec_valid_q[lane_q]) cur_choice = choice_q[lane_q];
		else if (cmd.scan_step && cand_ok) cur_choice = {1'b0, cand_q};
	end

	assign sts.req = req_q;
	assign sts.dest_rdy = dest_q;
	assign sts.lane_cached = dec_valid_q[lane_q];
	assign sts.lane_busy = still_lane;
	assign sts.scan_hit = cand_ok;
	assign sts.scan_last = (step_q + 5'd1 >= nsrc);
	assign sts.lane_match = src_ok && (cur_choice == {1'b0, src_q});
	assign sts.lane_last = ({1'b0, lane_q} + 3'd1 >= nlane);

	// Divider: restoring, one quotient bit per cycle
	logic [15:0] dividend_q, rem_q;
	logic [4:0]  div_cnt_q;
	logic [16:0] trial;
	logic [7:0]  bw_eff;
	assign bw_eff = (bw_q == 8'd0) ? 8'd1 : bw_q;
	assign trial = {rem_q, dividend_q[15]} - {9'd0, bw_eff};
	assign sts.div_done = (div_cnt_q == 5'd16);

	logic [31:0] until_c;
	assign until_c = cycle_q + {16'd0, dividend_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_q <= '0;
			last_q <= '0;
			dec_valid_q <= '0;
			for (int i = 0; i < MaxLanes; i++) lane_busy_q[i] <= 33'h1_0000_0000;
			for (int i = 0; i < MaxSources; i++) src_busy_q[i] <= 33'h1_0000_0000;
			lane_q <= '0;
			step_q <= '0;
			cand_q <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cmd.load) lane_q <= '0;
			if (cmd.tick) begin
				cycle_q <= cycle_q + 32'd1;
				dec_valid_q <= '0;
			end
			// Lane entry: a cached or busy lane decides at once
			if (cmd.lane_start) begin
				if (!dec_valid_q[lane_q]) begin
					if (still_lane) begin
						dec_valid_q[lane_q] <= 1'b1;
						choice_q[lane_q] <= 5'h10;
						if (!sts.lane_match && !sts.lane_last) lane_q <= lane_q + 1'b1;
					end else begin
						step_q <= '0;
						cand_q <= first_cand[SrcW-1:0];
					end
				end else if (!sts.lane_match && !sts.lane_last) lane_q <= lane_q + 1'b1;
			end
			// Round-robin scan, one source a cycle
			if (cmd.scan_step) begin
				if (cand_ok || sts.scan_last) begin
					dec_valid_q[lane_q] <= 1'b1;
					choice_q[lane_q] <= cand_ok ? {1'b0, cand_q} : 5'h10;
					if (cand_ok) last_q <= cand_q;
					if (!sts.lane_match && !sts.lane_last) lane_q <= lane_q + 1'b1;
				end else begin
					step_q <= step_q + 5'd1;
					cand_q <= ({1'b0, cand_q} + 5'd1 >= nsrc) ? '0 : cand_q + 1'b1;
				end
			end
			if (cmd.div_start) begin
				dividend_q <= (size_q == 16'd0) ? 16'd0 : size_q - 16'd1;
				rem_q <= '0;
				div_cnt_q <= '0;
			end
			if (cmd.div_step && !sts.div_done) begin
				div_cnt_q <= div_cnt_q + 5'd1;
				if (!trial[16]) begin
					rem_q <= trial[15:0];
					dividend_q <= {dividend_q[14:0], 1'b1};
				end else begin
					rem_q <= {rem_q[14:0], dividend_q[15]};
					dividend_q <= {dividend_q[14:0], 1'b0};
				end
			end
			// Stamp lane and source: quotient q gives until = cycle + q
			if (cmd.stamp) begin
				lane_busy_q[lane_q] <= {1'b0, until_c};
				src_busy_q[src_q] <= {1'b0, until_c};
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.res_tick || cmd.res_stall || cmd.res_nolane) begin
			status <= cmd.res_tick ? ST_TICK : (cmd.res_stall ? ST_STALL : ST_NOLANE);
			granted_lane <= '0;
			transfer_latency <= '0;
			busy_until <= '0;
		end else if (cmd.stamp) begin
			status <= ST_GRANT;
			granted_lane <= lane_q;
			transfer_latency <= dividend_q + 16'd1;
			busy_until <= until_c;
		end
	end
endmodule

[hdl/multi_lane_bus_round_robin_arbiter.sv]
// Tick or stall: no scan or division. A request visits the lanes in turn, scans the sources
// in round-robin order, and when granted runs the bit-serial division and the stamp.
// One item at a time; the next item is taken after the result transfer.
// The scan of sources and the bit-serial bandwidth divider set how long an item takes.
// Reset (arst_n low): cycle counter and last source cleared, all lanes and sources idle,
// bandwidth 8, 16 sources, 4 lanes.
module multi_lane_bus_round_robin_arbiter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [3:0]  source_index,
	input  logic [15:0] pkt_bytes,
	input  logic [15:0] head_ready_mask,
	input  logic        dest_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [1:0]  granted_lane,
	output logic [15:0] transfer_latency,
	output logic [31:0] busy_until
);
	import mlba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mlba_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	mlba_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_type(req_type), .source_index(source_index), .pkt_bytes(pkt_bytes),
		.head_ready_mask(head_ready_mask), .dest_ready(dest_ready),
		.cmd(cmd), .sts(sts),
		.status(status), .granted_lane(granted_lane),
		.transfer_latency(transfer_latency), .busy_until(busy_until)
	);
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
	import mlba_pkg::*;

	localparam int WatchdogLimit = 20000;
	localparam logic [1:0] RegUnused = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        req_type;
	logic [3:0]  source_index;
	logic [15:0] pkt_bytes;
	logic [15:0] head_ready_mask;
	logic        dest_ready;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [1:0]  granted_lane;
	logic [15:0] transfer_latency;
	logic [31:0] busy_until;

	typedef struct packed {
		logic [1:0]  st;
		logic [1:0]  lane;
		logic [15:0] lat;
		logic [31:0] busy_end;
	} arb_result_t;

	multi_lane_bus_round_robin_arbiter dut (.*);

	// clock
	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// arbiter shadow state; bit 32 marks idle / no decision
	logic [7:0]  bw_reg;
	logic [4:0]  nsrc_reg;
	logic [2:0]  nlane_reg;
	logic [31:0] cyc;
	logic [32:0] lane_until [MaxLanes];
	logic [32:0] lane_dec [MaxLanes];
	logic [4:0]  lane_pick [MaxLanes];
	logic [32:0] src_until [MaxSources];
	logic [3:0]  rr_last;

	arb_result_t grants_due[$];
	int errors = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int burst_left = 0;

	function automatic bit stamp_busy(logic [32:0] s);
		return !s[32] && s[31:0] >= cyc;
	endfunction

	function automatic void shadow_reset();
		bw_reg = 8'd8; nsrc_reg = 5'd16; nlane_reg = 3'd4; cyc = '0; rr_last = '0;
		for (int i = 0; i < MaxLanes; i++) begin
			lane_until[i] = 33'h1_0000_0000;
			lane_dec[i] = 33'h1_0000_0000;
			lane_pick[i] = 5'h10;
		end
		for (int i = 0; i < MaxSources; i++) src_until[i] = 33'h1_0000_0000;
	endfunction

	function automatic logic [4:0] pick_source(int l, logic [15:0] mask, int n);
		int s;
		if (!lane_dec[l][32] && lane_dec[l][31:0] == cyc) return lane_pick[l];
		lane_dec[l] = {1'b0, cyc};
		lane_pick[l] = 5'h10;
		if (stamp_busy(lane_until[l])) return 5'h10;
		for (int i = 0; i < n; i++) begin
			s = (rr_last + i + 1) % n;
			if (!mask[s] || stamp_busy(src_until[s])) continue;
			rr_last = 4'(s);
			lane_pick[l] = 5'(s);
			return 5'(s);
		end
		return 5'h10;
	endfunction

	function automatic arb_result_t arbitrate(logic rt, logic [3:0] src, logic [15:0] size,
			logic [15:0] mask, logic dr);
		arb_result_t r;
		int n, nl, l, bw, sz;
		logic [31:0] lat;
		r = '0;
		if (!rt) begin
			cyc = cyc + 32'd1;
			for (int i = 0; i < MaxLanes; i++) lane_dec[i] = 33'h1_0000_0000;
			r.st = ST_TICK;
			return r;
		end
		if (!dr) begin
			r.st = ST_STALL;
			return r;
		end
		n = nsrc_reg == 0 ? 1 : (nsrc_reg > MaxSources ? MaxSources : nsrc_reg);
		nl = nlane_reg == 0 ? 1 : (nlane_reg > MaxLanes ? MaxLanes : nlane_reg);
		for (l = 0; l < nl; l++)
			if (pick_source(l, mask, n) == {1'b0, src} && src < n) break;
		if (l >= nl) begin
			r.st = ST_NOLANE;
			return r;
		end
		bw = bw_reg == 0 ? 1 : bw_reg;
		sz = size == 0 ? 1 : size;
		lat = (sz - 1) / bw + 1;
		r.st = ST_GRANT;
		r.lane = 2'(l);
		r.lat = lat[15:0];
		r.busy_end = cyc + lat - 32'd1;
		lane_until[l] = {1'b0, r.busy_end};
		src_until[src] = {1'b0, r.busy_end};
		return r;
	endfunction

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		arb_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (grants_due.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result st=%0d", status);
			end else begin
				want = grants_due.pop_front();
				if (want !== {status, granted_lane, transfer_latency, busy_until}) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch exp st=%0d lane=%0d lat=%0d until=%0d got %0d %0d %0d %0d",
							want.st, want.lane, want.lat, want.busy_end,
							status, granted_lane, transfer_latency, busy_until);
				end
			end
		end
	end

	logic [3:0] stall_phase = 0;
	bit stall_on = 0;
	always @(negedge clk) begin
		stall_phase <= stall_phase + 4'd1;
		if (stall_phase == 0) stall_on <= ($urandom_range(0, 2) != 0);
		out_ready <= !stall_on || ($urandom_range(0, 3) != 0) || stall_phase[3];
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchdogLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_item(int rt, int src, int size, int mask, int dr);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= 1'(rt);
		source_index <= 4'(src);
		pkt_bytes <= 16'(size);
		head_ready_mask <= 16'(mask);
		dest_ready <= 1'(dr);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		grants_due.push_back(arbitrate(1'(rt), 4'(src), 16'(size), 16'(mask), 1'(dr)));
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain();
		while (grants_due.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BANDWIDTH: bw_reg = val;
			REG_SOURCES:   nsrc_reg = val[4:0];
			REG_LANES:     nlane_reg = val[2:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(int bw, int ns, int nl);
		drain();
		write_reg(REG_BANDWIDTH, 8'(bw));
		write_reg(REG_SOURCES, 8'(ns));
		write_reg(REG_LANES, 8'(nl));
	endtask

	task automatic test_directed();
		send_item(1, 0, 16'hffff, 16'hffff, 0);
		send_item(1, 1, 16'hffff, 16'h0002, 1);
		send_item(1, 1, 16'hffff, 16'h0002, 1);
		send_item(1, 2, 0, 16'h0004, 1);
		send_item(1, 15, 1, 16'h8000, 1);
		send_item(1, 3, 8, 16'h0000, 1);
		send_item(0, 0, 0, 0, 0);
		send_item(1, 4, 9, 16'hffff, 1);
		send_item(1, 5, 7, 16'h0020, 1);
		send_item(0, 15, 16'hffff, 16'hffff, 1);
		set_config(0, 0, 0);
		send_item(1, 1, 5, 16'h0001, 1);
		send_item(1, 0, 5, 16'h0001, 1);
		send_item(0, 0, 0, 0, 0);
		set_config(255, 31, 7);
		send_item(1, 9, 16'hffff, 16'h0200, 1);
		send_item(0, 0, 0, 0, 0);
		set_config(3, 4, 2);
		send_item(1, 8, 10, 16'hffff, 1);
		send_item(1, 2, 10, 16'hffff, 1);
		set_config(8, 16, 4);
		// a write to an unused index is ignored
		write_reg(RegUnused, 8'h55);
	endtask

	task automatic test_random(int count, int ns);
		int src;
		int mask;
		for (int i = 0; i < count; i++) begin
			src = $urandom_range(0, 15);
			if ($urandom_range(0, 9) < 7) src = $urandom_range(0, ns - 1);
			mask = $urandom_range(0, 65535);
			if ($urandom_range(0, 1) != 0) mask[src] = 1'b1;
			if ($urandom_range(0, 3) == 0)
				send_item(0, $urandom_range(0, 15), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 1));
			else
				send_item(1, src,
					$urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 40),
					mask, int'($urandom_range(0, 7) != 0));
		end
	endtask

	task automatic test_configs();
		set_config(8, 16, 4);   test_random(350, 16);
		set_config(1, 5, 1);    test_random(250, 5);
		set_config(255, 16, 4); test_random(250, 16);
		set_config(4, 1, 3);    test_random(150, 1);
		set_config(16, 12, 2);  test_random(330, 12);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; req_type = 0; source_index = 0; pkt_bytes = 0;
		head_ready_mask = 0; dest_ready = 0;
		shadow_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_configs();
		drain();
		if (errors == 0 && grants_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
